// ----- hw/rtl/tfr_pkg.sv -----
package tfr_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [7:0] LEN_BYTE  = 8'd9;
    localparam logic [7:0] CRC_POLY  = 8'hD5;
    localparam logic [7:0] CRC_INIT  = 8'h00;

    localparam int         PAYLOAD_BYTES = 8;
    localparam int         PAYLOAD_IDX_W = $clog2(PAYLOAD_BYTES);

    // byte position within a frame
    localparam logic [3:0] POS_HUNT  = 4'd0;
    localparam logic [3:0] POS_LEN   = 4'd1;
    localparam logic [3:0] POS_FIRST = 4'd2;
    localparam logic [3:0] POS_CRC   = 4'd10;

    localparam logic [19:0] SECS_PER_HOUR = 20'd3600;
    localparam logic [19:0] SECS_PER_MIN  = 20'd60;
    localparam logic [19:0] SECS_MAX      = 20'd933300;

    typedef enum logic [1:0] {
        ST_GOOD = 2'd0,
        ST_CRC  = 2'd1,
        ST_LEN  = 2'd2
    } t_status;

    typedef struct packed {
        t_status            frame_status;
        logic [15:0]        power_raw;
        logic [15:0]        cable_length_tenths;
        logic [7:0]         cable_speed_tenths;
        logic signed [7:0]  temperature_deg;
        logic [19:0]        flight_seconds;
    } t_result;

    // CRC-8, MSB first, one byte per call
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/tfr_frame_fsm.sv -----
module tfr_frame_fsm
    import tfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [3:0]               r_pos;
    logic [3:0]               n_pos;
    logic [7:0]               r_crc;
    logic [7:0]               n_crc;
    logic [7:0]               r_payload [PAYLOAD_BYTES];
    logic                     wr_en;
    logic [PAYLOAD_IDX_W-1:0] wr_idx;
    logic [3:0]               pos_ofs;

    assign pos_ofs = r_pos - POS_FIRST;
    assign wr_idx  = pos_ofs[PAYLOAD_IDX_W-1:0];

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        wr_en       = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.frame_status = ST_GOOD;
        case (r_pos)
            POS_LEN: begin
                if (i_byte == LEN_BYTE) begin
                    n_crc = crc_byte(CRC_INIT, i_byte);
                    n_pos = POS_FIRST;
                end else if (i_byte == SYNC_BYTE) begin
                    n_crc = CRC_INIT;
                    n_pos = POS_LEN;
                end else begin
                    n_crc              = CRC_INIT;
                    n_pos              = POS_HUNT;
                    o_res_valid        = 1'b1;
                    o_res.frame_status = ST_LEN;
                end
            end
            POS_CRC: begin
                n_pos       = POS_HUNT;
                n_crc       = CRC_INIT;
                o_res_valid = 1'b1;
                if (i_byte != r_crc) begin
                    o_res.frame_status = ST_CRC;
                end else begin
                    o_res.power_raw           = {r_payload[1], r_payload[0]};
                    o_res.cable_length_tenths = {r_payload[3], r_payload[2]};
                    o_res.cable_speed_tenths  = r_payload[4];
                    o_res.temperature_deg     = $signed(r_payload[5]);
                    o_res.flight_seconds      = 20'(r_payload[6]) * SECS_PER_HOUR
                                              + 20'(r_payload[7]) * SECS_PER_MIN;
                end
            end
            default: begin
                if (r_pos >= POS_FIRST && r_pos < POS_CRC) begin
                    wr_en = 1'b1;
                    n_crc = crc_byte(r_crc, i_byte);
                    n_pos = r_pos + 4'd1;
                end else begin
                    // hunting, also covers unused positions
                    n_crc = CRC_INIT;
                    n_pos = (i_byte == SYNC_BYTE) ? POS_LEN : POS_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_crc <= CRC_INIT;
        end else if (i_advance) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && wr_en) begin
            r_payload[wr_idx] <= i_byte;
        end
    end

endmodule

// ----- hw/rtl/tfr_out_reg.sv -----
module tfr_out_reg
    import tfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- hw/rtl/telemetry_frame_receiver.sv -----
// Telemetry frame receiver.
// Input channel: one serial byte per word on i_rx_byte, qualified by
// i_in_valid; o_in_stall holds the sender off. Output channel: one decoded
// frame or error report per word on the o_ fields, qualified by
// o_out_valid; i_out_stall from the receiver holds it.
// Frames are sync 0xAA, length 9, eight payload bytes, CRC-8 (poly 0xD5,
// init 0, MSB first) over length and payload. A bad length byte (not a
// repeated 0xAA, which restarts the frame) or a CRC mismatch gives one
// error word with all data fields zero. Throughput: one byte per cycle
// while the output is not stalled. A byte is taken into an input
// register, then parsed from there by the frame state machine, which
// loads the output register. When the output register holds a word
// under stall, the parser stops and the input register fills;
// o_in_stall then rises until the word is taken. Reset (synchronous,
// active low) empties both registers and returns the parser to hunting
// for sync. Payload bytes are not cleared.
module telemetry_frame_receiver
    import tfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_frame_status,
    output logic [15:0]       o_power_raw,
    output logic [15:0]       o_cable_length_tenths,
    output logic [7:0]        o_cable_speed_tenths,
    output logic signed [7:0] o_temperature_deg,
    output logic [19:0]       o_flight_seconds
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_ready;
    logic       advance;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign advance    = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    tfr_frame_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tfr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_frame_status        = out_res.frame_status;
    assign o_power_raw           = out_res.power_raw;
    assign o_cable_length_tenths = out_res.cable_length_tenths;
    assign o_cable_speed_tenths  = out_res.cable_speed_tenths;
    assign o_temperature_deg     = out_res.temperature_deg;
    assign o_flight_seconds      = out_res.flight_seconds;

    a_err_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status != ST_GOOD |->
            o_power_raw == 16'd0 && o_cable_length_tenths == 16'd0 &&
            o_cable_speed_tenths == 8'd0 && o_temperature_deg == 8'sd0 &&
            o_flight_seconds == 20'd0)
        else $error("error word carries data");

    a_secs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_flight_seconds <= SECS_MAX)
        else $error("flight seconds out of range");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && o_out_valid && i_out_stall)
        else $error("input stalled without a blocked output");

    a_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && $stable(r_in_byte))
        else $error("held byte lost");

endmodule
